### hdl/timestamped_capacity_lock_node_defines.svh
// Assertion macros for the capacity lock node.
// No dependencies; included by files that carry concurrent checks.
`ifndef TIMESTAMPED_CAPACITY_LOCK_NODE_DEFINES_SVH
`define TIMESTAMPED_CAPACITY_LOCK_NODE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCLN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tcln assertion failed");
// next-cycle implication
`define TCLN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tcln assertion failed");
`else
`define TCLN_ASSERT_NOW(label, clk, rstn, ante, cons)
`define TCLN_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hdl/tcln_pkg.sv
// Package for the capacity lock node: payload structs, codes, constants.
// No dependencies.
package tcln_pkg;

    localparam int MAX_NODES   = 16;
    localparam int STORE_DEPTH = 15;
    localparam int STORE_W     = 36;   // {sender[3:0], clock[31:0]}

    localparam logic signed [20:0] OCC_MAX = 21'sd1048575;
    localparam logic signed [20:0] OCC_MIN = -21'sd1048576;

    // operation codes
    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_EXIT    = 3'd1;
    localparam logic [2:0] OP_WANT    = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_PERMIT  = 3'd4;

    // outgoing message kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_WANT    = 2'd1;
    localparam logic [1:0] KIND_PERMIT  = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_NODE_ID    = 3'd0;
    localparam logic [2:0] CFG_NODE_COUNT = 3'd1;
    localparam logic [2:0] CFG_GROUP_SIZE = 3'd2;
    localparam logic [2:0] CFG_ROAD0_CAP  = 3'd3;
    localparam logic [2:0] CFG_ROAD1_CAP  = 3'd4;

    localparam logic [3:0]  RST_NODE_ID    = 4'd0;
    localparam logic [4:0]  RST_NODE_COUNT = 5'd2;
    localparam logic [15:0] RST_GROUP_SIZE = 16'd250;
    localparam logic [15:0] RST_ROAD0_CAP  = 16'd330;
    localparam logic [15:0] RST_ROAD1_CAP  = 16'd340;

    typedef struct packed {
        logic [2:0]  operation;
        logic        road;
        logic [3:0]  sender;
        logic [31:0] src_clock;
        logic [15:0] amount;
        logic [31:0] echoed_request_clock;
    } tcln_in_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [3:0]  dest;
        logic [31:0] msg_clock;
        logic        msg_road;
        logic [15:0] msg_value;
        logic [31:0] msg_request_clock;
        logic        enter;
        logic        last;
    } tcln_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BCAST,
        ST_REL_RD,
        ST_REL_OUT,
        ST_SINGLE
    } tcln_state_t;

endpackage

### hdl/tcln_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcln_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/timestamped_capacity_lock_node.sv
// Top level of one node of a Lamport-timestamped, capacity-limited lock.
// Depends on tcln_pkg, tcln_ram and timestamped_capacity_lock_node_defines.svh.
`include "timestamped_capacity_lock_node_defines.svh"

// One node of a two-resource, k-unit Ricart-Agrawala lock. Each input
// transaction is a local request, a local exit, or a received want, release
// or permission message; each output transaction is one outgoing message
// (want, permission, release) or a "nothing" marker, with last set on the
// final one of an event and enter reporting whether the node may now enter.
// Items are handled one at a time. A received message or an unused code
// goes through accept, execute and load the result. A request walks the
// node indexes up to its last want, own index included, and goes the same
// way as a received message when no want is sent. An exit sends a release
// per deferred requester, each read from the deferred-requester RAM
// (registered read) before it is sent, and goes that way with an empty store.
// The output register frees the input side: the next transaction is taken
// while the final result still waits on m_ready. Backpressure on m_ready
// holds each output until it is taken. Configuration writes are
// always accepted (cfg_ready tied high) and must only arrive while idle.
// The deferred store has no reset; only entries below the fill count are
// ever read, and reads (exit) and writes (want) never overlap in time.
module timestamped_capacity_lock_node
    import tcln_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  tcln_in_t  s_data,

    output logic      m_valid,
    input  logic      m_ready,
    output tcln_out_t m_data,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // configuration
    logic [3:0]  node_id_reg;
    logic [4:0]  node_count_reg;
    logic [15:0] group_size_reg;
    logic [15:0] road0_cap_reg;
    logic [15:0] road1_cap_reg;

    // node state
    tcln_state_t state_reg, state_next;
    logic [31:0] clock_reg, clock_next;
    logic        wanting_reg, wanting_next;
    logic        road_reg, road_next;
    logic [31:0] req_clock_reg, req_clock_next;
    logic [3:0]  pending_reg, pending_next;
    logic signed [20:0] occ_reg, occ_next;
    logic [3:0]  count_reg, count_next;

    // item and sequencing
    tcln_in_t    item_reg, item_next;
    logic [4:0]  bc_idx_reg, bc_idx_next;
    logic [3:0]  bc_sent_reg, bc_sent_next;
    logic [ADDR_W-1:0] rel_idx_reg, rel_idx_next;
    logic [1:0]  sgl_kind_reg, sgl_kind_next;
    logic [3:0]  sgl_dest_reg, sgl_dest_next;
    logic [31:0] sgl_clock_reg, sgl_clock_next;
    logic [15:0] sgl_value_reg, sgl_value_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    tcln_out_t   m_data_reg, m_data_next;
    logic        out_load;
    logic        out_free;

    // store port
    logic                ram_we;
    logic                ram_re;
    logic [STORE_W-1:0]  ram_wdata;
    logic [STORE_W-1:0]  ram_rdata;

    // datapath helpers
    logic [31:0] rx_clock;
    logic        defer;
    logic [4:0]  lim;
    logic        own_in_range;
    logic [4:0]  n_req5;
    logic signed [21:0] occ_wide;
    logic signed [21:0] occ_add;
    logic signed [21:0] occ_sub;
    logic signed [20:0] occ_add_sat;
    logic signed [20:0] occ_sub_sat;
    logic [15:0] cap_sel;
    logic signed [22:0] room;
    logic        enter_w;

    tcln_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rel_idx_reg),
        .rd_data (ram_rdata)
    );

    assign ram_wdata = {item_reg.sender, item_reg.src_clock};

    // Lamport receive update: max(local, remote) + 1, wrapping
    assign rx_clock = ((clock_reg > item_reg.src_clock) ? clock_reg
                                                        : item_reg.src_clock) + 32'd1;

    // older request (smaller clock, then smaller id) wins and defers the sender
    assign defer = wanting_reg && (road_reg == item_reg.road) &&
                   ((req_clock_reg < item_reg.src_clock) ||
                    ((req_clock_reg == item_reg.src_clock) &&
                     (node_id_reg < item_reg.sender)));

    // number of wants in a broadcast
    assign lim          = (node_count_reg > 5'(MAX_NODES)) ? 5'(MAX_NODES) : node_count_reg;
    assign own_in_range = ({1'b0, node_id_reg} < lim);
    assign n_req5       = lim - {4'd0, own_in_range};

    // saturating occupancy update
    assign occ_wide = {occ_reg[20], occ_reg};
    assign occ_add  = occ_wide + $signed({6'd0, item_reg.amount});
    assign occ_sub  = occ_wide - $signed({6'd0, item_reg.amount});
    assign occ_add_sat = (occ_add[21] != occ_add[20]) ?
                         (occ_add[21] ? OCC_MIN : OCC_MAX) : occ_add[20:0];
    assign occ_sub_sat = (occ_sub[21] != occ_sub[20]) ?
                         (occ_sub[21] ? OCC_MIN : OCC_MAX) : occ_sub[20:0];

    // entry test on the settled state
    assign cap_sel = road_reg ? road1_cap_reg : road0_cap_reg;
    assign room    = $signed({7'd0, cap_sel}) - $signed({{2{occ_reg[20]}}, occ_reg});
    assign enter_w = wanting_reg && (pending_reg == 4'd0) &&
                     ($signed({7'd0, group_size_reg}) < room);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        wanting_next   = wanting_reg;
        road_next      = road_reg;
        req_clock_next = req_clock_reg;
        pending_next   = pending_reg;
        occ_next       = occ_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        bc_idx_next    = bc_idx_reg;
        bc_sent_next   = bc_sent_reg;
        rel_idx_next   = rel_idx_reg;
        sgl_kind_next  = sgl_kind_reg;
        sgl_dest_next  = sgl_dest_reg;
        sgl_clock_next = sgl_clock_reg;
        sgl_value_next = sgl_value_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        m_data_next    = m_data_reg;
        s_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                sgl_kind_next  = KIND_NONE;
                sgl_dest_next  = 4'd0;
                sgl_clock_next = 32'd0;
                sgl_value_next = 16'd0;
                state_next     = ST_SINGLE;
                unique case (item_reg.operation)
                    OP_REQUEST: begin
                        clock_next     = clock_reg + 32'd1;
                        req_clock_next = clock_reg + 32'd1;
                        wanting_next   = 1'b1;
                        road_next      = item_reg.road;
                        occ_next       = '0;
                        pending_next   = n_req5[3:0];
                        bc_idx_next    = 5'd0;
                        bc_sent_next   = 4'd0;
                        if (n_req5 != 5'd0) begin
                            state_next = ST_BCAST;
                        end
                    end
                    OP_EXIT: begin
                        count_next   = 4'd0;
                        wanting_next = 1'b0;
                        if (count_reg != 4'd0) begin
                            rel_idx_next = ADDR_W'(count_reg - 4'd1);
                            state_next   = ST_REL_RD;
                        end
                    end
                    OP_WANT: begin
                        clock_next     = rx_clock;
                        sgl_kind_next  = KIND_PERMIT;
                        sgl_dest_next  = item_reg.sender;
                        sgl_clock_next = clock_reg;
                        if (defer) begin
                            sgl_value_next = group_size_reg;
                            if (count_reg < 4'(STORE_DEPTH)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 4'd1;
                            end
                        end
                    end
                    OP_RELEASE: begin
                        clock_next = rx_clock;
                        if (wanting_reg && (road_reg == item_reg.road) &&
                            (req_clock_reg == item_reg.echoed_request_clock)) begin
                            occ_next = occ_sub_sat;
                        end
                    end
                    OP_PERMIT: begin
                        clock_next = rx_clock;
                        if (pending_reg != 4'd0) begin
                            pending_next = pending_reg - 4'd1;
                        end
                        occ_next = occ_add_sat;
                    end
                    default: begin
                        // undefined codes leave the state alone
                    end
                endcase
            end

            ST_BCAST: begin
                if (bc_idx_reg == {1'b0, node_id_reg}) begin
                    bc_idx_next = bc_idx_reg + 5'd1;
                end else if (out_free) begin
                    out_load                      = 1'b1;
                    m_data_next.send_kind         = KIND_WANT;
                    m_data_next.dest              = bc_idx_reg[3:0];
                    m_data_next.msg_clock         = req_clock_reg;
                    m_data_next.msg_road          = road_reg;
                    m_data_next.msg_value         = 16'd0;
                    m_data_next.msg_request_clock = 32'd0;
                    m_data_next.enter             = enter_w;
                    m_data_next.last              = (bc_sent_reg == pending_reg - 4'd1);
                    bc_idx_next  = bc_idx_reg + 5'd1;
                    bc_sent_next = bc_sent_reg + 4'd1;
                    if (bc_sent_reg == pending_reg - 4'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_REL_RD: begin
                ram_re     = 1'b1;
                state_next = ST_REL_OUT;
            end

            ST_REL_OUT: begin
                if (out_free) begin
                    out_load                      = 1'b1;
                    m_data_next.send_kind         = KIND_RELEASE;
                    m_data_next.dest              = ram_rdata[35:32];
                    m_data_next.msg_clock         = clock_reg;
                    m_data_next.msg_road          = road_reg;
                    m_data_next.msg_value         = group_size_reg;
                    m_data_next.msg_request_clock = ram_rdata[31:0];
                    m_data_next.enter             = enter_w;
                    m_data_next.last              = (rel_idx_reg == '0);
                    if (rel_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rel_idx_next = rel_idx_reg - ADDR_W'(1);
                        state_next   = ST_REL_RD;
                    end
                end
            end

            ST_SINGLE: begin
                if (out_free) begin
                    out_load                      = 1'b1;
                    m_data_next.send_kind         = sgl_kind_reg;
                    m_data_next.dest              = sgl_dest_reg;
                    m_data_next.msg_clock         = sgl_clock_reg;
                    m_data_next.msg_road          = 1'b0;
                    m_data_next.msg_value         = sgl_value_reg;
                    m_data_next.msg_request_clock = 32'd0;
                    m_data_next.enter             = enter_w;
                    m_data_next.last              = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and node state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            clock_reg     <= 32'd0;
            wanting_reg   <= 1'b0;
            road_reg      <= 1'b0;
            req_clock_reg <= 32'd0;
            pending_reg   <= 4'd0;
            occ_reg       <= '0;
            count_reg     <= 4'd0;
            bc_idx_reg    <= 5'd0;
            bc_sent_reg   <= 4'd0;
            rel_idx_reg   <= '0;
        end else begin
            m_valid_reg   <= m_valid_next;
            clock_reg     <= clock_next;
            wanting_reg   <= wanting_next;
            road_reg      <= road_next;
            req_clock_reg <= req_clock_next;
            pending_reg   <= pending_next;
            occ_reg       <= occ_next;
            count_reg     <= count_next;
            bc_idx_reg    <= bc_idx_next;
            bc_sent_reg   <= bc_sent_next;
            rel_idx_reg   <= rel_idx_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        sgl_kind_reg  <= sgl_kind_next;
        sgl_dest_reg  <= sgl_dest_next;
        sgl_clock_reg <= sgl_clock_next;
        sgl_value_reg <= sgl_value_next;
        m_data_reg    <= m_data_next;
    end

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= RST_NODE_ID;
            node_count_reg <= RST_NODE_COUNT;
            group_size_reg <= RST_GROUP_SIZE;
            road0_cap_reg  <= RST_ROAD0_CAP;
            road1_cap_reg  <= RST_ROAD1_CAP;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NODE_ID:    node_id_reg    <= cfg_data[3:0];
                CFG_NODE_COUNT: node_count_reg <= cfg_data[4:0];
                CFG_GROUP_SIZE: group_size_reg <= cfg_data;
                CFG_ROAD0_CAP:  road0_cap_reg  <= cfg_data;
                CFG_ROAD1_CAP:  road1_cap_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // a broadcast is only entered with at least one want to send
    `TCLN_ASSERT_NOW(a_bcast_has_wants, aclk, aresetn, state_reg == ST_BCAST, pending_reg != 4'd0)
    // the fill count never passes the store depth
    `TCLN_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= 4'(STORE_DEPTH))
    // an exit empties the store and drops the request
    `TCLN_ASSERT_NEXT(a_exit_clears, aclk, aresetn, (state_reg == ST_EXEC) && (item_reg.operation == OP_EXIT), (count_reg == 4'd0) && !wanting_reg)

endmodule
